>>> sv/abl_pkg.sv
// ----------------------------------------------------------------------------
// abl_pkg
// shared types, codes and helpers for the bit link framer
// ----------------------------------------------------------------------------
package abl_pkg;

    localparam int ABL_BUFFER_BYTES = 16;

    localparam logic [7:0] SYM_START   = 8'hBE;
    localparam logic [7:0] SYM_DUMMY   = 8'hBF;
    localparam logic [7:0] SYM_END     = 8'hED;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] PATTERN_RST = 8'hEC;

    typedef enum logic [1:0] {
        CFG_CAL_ENABLE = 2'd0,
        CFG_SYNC_PAT   = 2'd1,
        CFG_PROMISC    = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_CALIB     = 3'd1,
        EV_RAW       = 3'd2,
        EV_LEN_HI    = 3'd3,
        EV_LEN_LO    = 3'd4,
        EV_PAYLOAD   = 3'd5,
        EV_END_OK    = 3'd6,
        EV_END_MISS  = 3'd7
    } t_rx_event;

    typedef enum logic [1:0] {
        DF_WAIT    = 2'd0,
        DF_LEN_HI  = 2'd1,
        DF_LEN_LO  = 2'd2,
        DF_PAYLOAD = 2'd3
    } t_df_state;

    typedef struct packed {
        logic       cal_en;
        logic [7:0] pattern;
        logic       promisc;
    } t_cfg;

    // upper-case hex ascii of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] n8;
        n8 = {4'h0, n};
        return (n < 4'd10) ? (8'h30 + n8) : (8'h37 + n8);
    endfunction

    // ascii length character to nibble, modulo 16
    function automatic logic [3:0] char_nibble(input logic [7:0] a);
        return (a <= 8'h39) ? a[3:0] : (a[3:0] + 4'd9);
    endfunction

endpackage

>>> sv/abl_rx.sv
// ----------------------------------------------------------------------------
// abl_rx
// receive shifter, sync detection, byte assembly and packet deframer
// ----------------------------------------------------------------------------
module abl_rx
    import abl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  logic       i_bit,
    input  t_cfg       i_cfg,
    output logic       o_cal_next,
    output t_rx_event  o_event,
    output logic [7:0] o_byte
);

    logic [7:0] r_shift, n_shift;
    logic [2:0] r_bits_left, n_bits_left;
    logic       r_cal, n_cal;
    t_df_state  r_df, n_df;
    logic [7:0] r_exp, n_exp;
    logic [7:0] r_cnt, n_cnt;

    logic [7:0] shift_in;
    logic       cal_mode;
    logic       byte_done;
    logic [3:0] nib;

    always_comb begin
        shift_in  = {r_shift[6:0], i_bit};
        cal_mode  = i_cfg.cal_en && !r_cal;
        byte_done = i_tick && !cal_mode && (r_bits_left == 3'd0);
        nib       = char_nibble(shift_in);
    end

    // next state
    always_comb begin
        n_shift     = r_shift;
        n_bits_left = r_bits_left;
        n_cal       = r_cal;
        n_df        = r_df;
        n_exp       = r_exp;
        n_cnt       = r_cnt;
        if (i_tick) begin
            if (cal_mode) begin
                n_shift = shift_in;
                if (shift_in == i_cfg.pattern) begin
                    n_cal = 1'b1;
                end
            end else if (r_bits_left != 3'd0) begin
                n_shift     = shift_in;
                n_bits_left = r_bits_left - 3'd1;
            end else begin
                n_shift     = 8'h00;
                n_bits_left = 3'd7;
                if (!i_cfg.promisc) begin
                    case (r_df)
                        DF_WAIT: begin
                            if (shift_in == SYM_START) begin
                                n_df = DF_LEN_HI;
                            end
                        end
                        DF_LEN_HI: begin
                            n_exp = {nib, 4'h0};
                            n_df  = DF_LEN_LO;
                        end
                        DF_LEN_LO: begin
                            n_exp = {r_exp[7:4], nib};
                            n_cnt = 8'h00;
                            n_df  = DF_PAYLOAD;
                        end
                        DF_PAYLOAD: begin
                            if (r_cnt < r_exp) begin
                                n_cnt = r_cnt + 8'd1;
                            end else begin
                                n_df = DF_WAIT;
                            end
                        end
                        default: n_df = DF_WAIT;
                    endcase
                end
            end
        end
    end

    // event outputs
    always_comb begin
        o_event = EV_NONE;
        o_byte  = 8'h00;
        if (i_tick && cal_mode && (shift_in == i_cfg.pattern)) begin
            o_event = EV_CALIB;
            o_byte  = shift_in;
        end else if (byte_done) begin
            if (i_cfg.promisc) begin
                if (!(i_cfg.cal_en && shift_in == i_cfg.pattern)
                    && shift_in != 8'h00 && shift_in != 8'hFF) begin
                    o_event = EV_RAW;
                    o_byte  = shift_in;
                end
            end else begin
                case (r_df)
                    DF_WAIT: o_event = EV_NONE;
                    DF_LEN_HI: begin
                        o_event = EV_LEN_HI;
                        o_byte  = shift_in;
                    end
                    DF_LEN_LO: begin
                        o_event = EV_LEN_LO;
                        o_byte  = shift_in;
                    end
                    DF_PAYLOAD: begin
                        if (r_cnt < r_exp) begin
                            o_event = EV_PAYLOAD;
                        end else if (shift_in == SYM_END) begin
                            o_event = EV_END_OK;
                        end else begin
                            o_event = EV_END_MISS;
                        end
                        o_byte = shift_in;
                    end
                    default: o_event = EV_NONE;
                endcase
            end
        end
    end

    assign o_cal_next = n_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= 8'h00;
            r_bits_left <= 3'd7;
            r_cal       <= 1'b0;
            r_df        <= DF_WAIT;
            r_exp       <= 8'h00;
            r_cnt       <= 8'h00;
        end else begin
            r_shift     <= n_shift;
            r_bits_left <= n_bits_left;
            r_cal       <= n_cal;
            r_df        <= n_df;
            r_exp       <= n_exp;
            r_cnt       <= n_cnt;
        end
    end

endmodule

>>> sv/abl_tx.sv
// ----------------------------------------------------------------------------
// abl_tx
// message store, commit logic and frame / calibration pattern transmitter
// ----------------------------------------------------------------------------
module abl_tx
    import abl_pkg::*;
#(
    parameter int BUFFER_BYTES = ABL_BUFFER_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  logic       i_char_en,
    input  logic [7:0] i_char,
    input  t_cfg       i_cfg,
    input  logic       i_cal_next,
    output logic       o_level,
    output logic       o_committed,
    output logic       o_busy
);

    localparam int W_LEN  = $clog2(BUFFER_BYTES + 1);
    localparam int W_ADDR = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    // frame position held as index plus four, so the leading symbols start at 0
    localparam int W_IDX  = $clog2(BUFFER_BYTES + 6);

    localparam logic [W_IDX-1:0] POS_DUMMY  = W_IDX'(0);
    localparam logic [W_IDX-1:0] POS_START  = W_IDX'(1);
    localparam logic [W_IDX-1:0] POS_LEN_HI = W_IDX'(2);
    localparam logic [W_IDX-1:0] POS_LEN_LO = W_IDX'(3);
    localparam logic [W_IDX-1:0] POS_DATA   = W_IDX'(4);

    logic [7:0]       mem [BUFFER_BYTES];
    logic [7:0]       r_rd_data;

    logic [W_LEN-1:0] r_fill, n_fill;
    logic [W_LEN-1:0] r_len, n_len;
    logic             r_ready, n_ready;
    logic [W_IDX-1:0] r_pos, n_pos;
    logic [2:0]       r_bit, n_bit;
    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_fb, n_fb;
    logic             r_level, n_level;

    logic             wr_en;
    logic [W_ADDR-1:0] rd_addr;
    logic [W_IDX-1:0] len_pos;
    logic [7:0]       len8;
    logic [7:0]       sel_byte;
    logic             committed;

    always_comb begin
        len_pos = W_IDX'(r_len) + POS_DATA;
        len8    = 8'(r_len);
        if (r_pos == POS_DUMMY) begin
            sel_byte = SYM_DUMMY;
        end else if (r_pos == POS_START) begin
            sel_byte = SYM_START;
        end else if (r_pos == POS_LEN_HI) begin
            sel_byte = hex_char(len8[7:4]);
        end else if (r_pos == POS_LEN_LO) begin
            sel_byte = hex_char(len8[3:0]);
        end else if (r_pos < len_pos) begin
            sel_byte = r_rd_data;
        end else if (r_pos == len_pos) begin
            sel_byte = SYM_END;
        end else begin
            sel_byte = SYM_DUMMY;
        end
    end

    always_comb begin
        n_fill    = r_fill;
        n_len     = r_len;
        n_ready   = r_ready;
        n_pos     = r_pos;
        n_bit     = r_bit;
        n_phase   = r_phase;
        n_fb      = r_fb;
        n_level   = r_level;
        wr_en     = 1'b0;
        committed = 1'b0;
        if (i_char_en && !r_ready) begin
            if (i_char == CHAR_NL) begin
                if (r_fill != '0) begin
                    n_len     = r_fill;
                    n_ready   = 1'b1;
                    n_fill    = '0;
                    committed = 1'b1;
                end
            end else if (r_fill < W_LEN'(BUFFER_BYTES)) begin
                wr_en  = 1'b1;
                n_fill = r_fill + W_LEN'(1);
            end
        end
        if (i_tick) begin
            if (r_ready && r_phase == 3'd7) begin
                if (r_bit == 3'd7) begin
                    n_fb = sel_byte;
                end
                n_level = n_fb[r_bit];
                if (r_bit == 3'd0) begin
                    n_bit = 3'd7;
                    if (r_pos >= len_pos + W_IDX'(1)) begin
                        n_pos   = POS_DUMMY;
                        n_ready = 1'b0;
                    end else begin
                        n_pos = r_pos + W_IDX'(1);
                    end
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end else begin
                if (i_cfg.cal_en && !i_cal_next) begin
                    n_level = i_cfg.pattern[r_phase];
                end
                n_phase = r_phase - 3'd1;
            end
        end
    end

    // read runs ahead on the next position so payload data for the current position is already registered
    assign rd_addr = W_ADDR'(n_pos - POS_DATA);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[W_ADDR'(r_fill)] <= i_char;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_len   <= '0;
            r_ready <= 1'b0;
            r_pos   <= POS_DUMMY;
            r_bit   <= 3'd7;
            r_phase <= 3'd7;
            r_fb    <= 8'h00;
            r_level <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_ready <= n_ready;
            r_pos   <= n_pos;
            r_bit   <= n_bit;
            r_phase <= n_phase;
            r_fb    <= n_fb;
            r_level <= n_level;
        end
    end

    assign o_level     = n_level;
    assign o_committed = committed;
    assign o_busy      = n_ready;

endmodule

>>> sv/ask_bit_link_framer_unit.sv
// ----------------------------------------------------------------------------
// ask_bit_link_framer_unit
// bit-serial link framer with calibration, message buffer and packet deframer
// ----------------------------------------------------------------------------
// One input beat is either a bit tick carrying the sampled receive level or a
// host character. Every accepted beat yields exactly one output beat, moving
// from the input register into the result register; a new beat is accepted in
// every cycle, set only by the input register / result register pair, so the
// throughput is one beat per clock while the output side keeps up. Host
// characters fill a message buffer and a newline commits a non-empty message;
// the transmitter then sends dummy, start, two hex length chars, payload, end
// and dummy, MSB first, one bit per tick. While calibration is enabled and the
// link is not yet locked, the sync pattern is repeated on the line. The
// message buffer has no reset and is only used at positions already written.
// Configuration writes take effect at once and belong to idle periods.
module ask_bit_link_framer_unit
    import abl_pkg::*;
#(
    parameter int BUFFER_BYTES = ABL_BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] rx_bit, [8:1] host_char, rest zero
    input  logic        s_axis_tuser,   // cmd: 0 bit tick, 1 host character
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] tx_level, [3:1] rx_event, [11:4] rx_byte,
                                        // [12] msg_committed, [13] tx_busy, rest zero
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // configuration registers
    t_cfg       r_cfg;

    // input register
    logic       r_in_valid;
    logic       r_in_cmd;
    logic       r_in_bit;
    logic [7:0] r_in_char;

    // result register
    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic       advance;
    logic       tick;
    logic       char_en;
    logic       cal_next;
    t_rx_event  rx_event;
    logic [7:0] rx_byte;
    logic       tx_level;
    logic       committed;
    logic       busy;

    // the working stage fires when the result register is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign tick          = advance && !r_in_cmd;
    assign char_en       = advance && r_in_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_en  <= 1'b1;
            r_cfg.pattern <= PATTERN_RST;
            r_cfg.promisc <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAL_ENABLE: r_cfg.cal_en  <= i_cfg_data[0];
                CFG_SYNC_PAT:   r_cfg.pattern <= i_cfg_data;
                CFG_PROMISC:    r_cfg.promisc <= i_cfg_data[0];
                default:        r_cfg         <= r_cfg;
            endcase
        end
    end

    // input register: takes a beat whenever the previous one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_bit  <= s_axis_tdata[0];
            r_in_char <= s_axis_tdata[8:1];
        end
    end

    abl_rx u_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick),
        .i_bit      (r_in_bit),
        .i_cfg      (r_cfg),
        .o_cal_next (cal_next),
        .o_event    (rx_event),
        .o_byte     (rx_byte)
    );

    abl_tx #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_char_en   (char_en),
        .i_char      (r_in_char),
        .i_cfg       (r_cfg),
        .i_cal_next  (cal_next),
        .o_level     (tx_level),
        .o_committed (committed),
        .o_busy      (busy)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {2'b00, busy, committed, rx_byte, rx_event, tx_level};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> sv/abl_checker.sv
// ----------------------------------------------------------------------------
// abl_checker
// port-level checks for the bit link framer
// ----------------------------------------------------------------------------
module abl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // an output beat waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // a committing beat always reports the transmitter busy
    a_commit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[13])
        else $error("commit without busy");

    // no receive event carries no byte
    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3:1] == 3'd0 |-> m_axis_tdata[11:4] == 8'h00)
        else $error("byte reported without event");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind ask_bit_link_framer_unit abl_checker u_abl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/ask_bit_link_framer_unit_tb.sv
// ----------------------------------------------------------------------------
// ask_bit_link_framer_unit_tb
// self-checking stream testbench for the bit link framer
// ----------------------------------------------------------------------------
// Drives bit ticks and host characters into the input stream and keeps its own
// cycle-true model of the receiver, the deframer, the message buffer and the
// frame transmitter. Every accepted input beat queues one expected output
// beat, and a free-running sink process compares every output beat field by
// field. Directed sequences hit calibration, the raw byte filter, the store
// limits and the deframer corner cases; random episodes then mix host
// messages sent over a loopback of the line, hand-built frames, broken frames
// and noise, under several register settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module ask_bit_link_framer_unit_tb;
    import abl_pkg::*;

    // filler bytes that the raw byte reporter never passes on
    localparam logic [7:0] IDLE_LOW  = 8'h00;
    localparam logic [7:0] IDLE_HIGH = 8'hFF;

    // stop offering new stimulus once this many beats went in
    localparam int TARGET_BEATS = 550;

    // one expected output beat
    typedef struct packed {
        logic       tx_level;
        t_rx_event  rx_event;
        logic [7:0] rx_byte;
        logic       committed;
        logic       busy;
    } t_link_result;

    // dut ports, all known from time zero
    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // [0] rx_bit, [8:1] host_char, rest zero
    logic        s_axis_tuser  = 1'b0;   // cmd: 0 bit tick, 1 host character
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;           // [0] tx_level, [3:1] rx_event, [11:4] rx_byte,
                                         // [12] msg_committed, [13] tx_busy, rest zero
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [7:0]  i_cfg_data    = '0;

    // register copies as the block should hold them
    logic        cfg_cal     = 1'b1;
    logic [7:0]  cfg_pat     = PATTERN_RST;
    logic        cfg_promisc = 1'b1;

    // receiver side of the link model
    logic [7:0]  rx_shift   = '0;
    logic [2:0]  rx_left    = 3'd7;
    logic        locked     = 1'b0;
    t_df_state   df_state   = DF_WAIT;
    logic [7:0]  exp_len    = '0;
    logic [8:0]  rcv_cnt    = '0;

    // message buffer and transmitter side of the link model
    logic [7:0]  msg_buf [ABL_BUFFER_BYTES];
    logic [4:0]  fill_idx   = '0;
    logic [4:0]  msg_len    = '0;
    logic        msg_ready  = 1'b0;
    int          fb_idx     = -4;
    logic [2:0]  fb_bit     = 3'd7;
    logic [2:0]  pat_phase  = 3'd7;
    logic [7:0]  fb_byte    = '0;
    logic        line_lvl   = 1'b0;

    // expected output beats, oldest first
    t_link_result pending_results[$];

    // run bookkeeping
    int beats_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int n_calib      = 0;
    int n_raw        = 0;
    int n_payload    = 0;
    int n_end_ok     = 0;
    int n_end_miss   = 0;
    int n_commit     = 0;

    // idling controls shared by the sender, the sink and the tests
    bit src_gaps_on  = 1'b1;
    bit sink_gaps_on = 1'b1;
    int hold_off     = 0;

    ask_bit_link_framer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // generous ceiling on the whole run
    initial begin
        #1000000;
        $display("ask_bit_link_framer_unit_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // link model
    // ------------------------------------------------------------------------

    // nibble to upper-case hex ascii
    function automatic logic [7:0] nibble_to_ascii(input logic [3:0] n);
        return (n <= 4'd9) ? {4'h3, n} : 8'h40 + {4'h0, n - 4'd9};
    endfunction

    // length character to nibble; digits by value, anything else as a letter
    function automatic logic [3:0] ascii_to_nibble(input logic [7:0] a);
        return (a < 8'h3A) ? a[3:0] : 4'(a[3:0] - 4'd7);
    endfunction

    // one received bit: calibration hunt, byte assembly, raw filter or deframer
    function automatic void shift_in_rx_bit(input logic b, output t_rx_event ev,
                                            output logic [7:0] data);
        logic [7:0] rb;
        ev   = EV_NONE;
        data = '0;
        rx_shift = {rx_shift[6:0], b};
        // hunting for the sync pattern, byte counter untouched
        if (cfg_cal && !locked) begin
            if (rx_shift == cfg_pat) begin
                locked = 1'b1;
                ev     = EV_CALIB;
                data   = rx_shift;
            end
            return;
        end
        if (rx_left != 3'd0) begin
            rx_left = rx_left - 3'd1;
            return;
        end
        rb = rx_shift;
        if (cfg_promisc) begin
            // pattern is only filtered while calibration is on
            if (!(cfg_cal && rb == cfg_pat) && rb != IDLE_LOW && rb != IDLE_HIGH) begin
                ev   = EV_RAW;
                data = rb;
            end
        end else begin
            case (df_state)
                DF_WAIT: begin
                    if (rb == SYM_START)
                        df_state = DF_LEN_HI;
                end
                DF_LEN_HI: begin
                    exp_len  = {ascii_to_nibble(rb), 4'h0};
                    df_state = DF_LEN_LO;
                    ev       = EV_LEN_HI;
                    data     = rb;
                end
                DF_LEN_LO: begin
                    exp_len[3:0] = ascii_to_nibble(rb);
                    df_state     = DF_PAYLOAD;
                    rcv_cnt      = '0;
                    ev           = EV_LEN_LO;
                    data         = rb;
                end
                default: begin
                    if (rcv_cnt < {1'b0, exp_len}) begin
                        rcv_cnt = rcv_cnt + 9'd1;
                        ev      = EV_PAYLOAD;
                    end else begin
                        ev       = (rb == SYM_END) ? EV_END_OK : EV_END_MISS;
                        df_state = DF_WAIT;
                    end
                    data = rb;
                end
            endcase
        end
        rx_left  = 3'd7;
        rx_shift = '0;
    endfunction

    // one transmitted bit: frame bits once aligned, else the pattern wheel
    function automatic void advance_tx_bit();
        int len;
        len = int'(msg_len);
        if (msg_ready && pat_phase == 3'd7) begin
            // pick the next frame byte on its top bit
            if (fb_bit == 3'd7) begin
                if (fb_idx == -4)
                    fb_byte = SYM_DUMMY;
                else if (fb_idx == -3)
                    fb_byte = SYM_START;
                else if (fb_idx == -2)
                    fb_byte = nibble_to_ascii({3'b000, msg_len[4]});
                else if (fb_idx == -1)
                    fb_byte = nibble_to_ascii(msg_len[3:0]);
                else if (fb_idx < len)
                    fb_byte = msg_buf[fb_idx];
                else if (fb_idx == len)
                    fb_byte = SYM_END;
                else
                    fb_byte = SYM_DUMMY;
            end
            line_lvl = fb_byte[fb_bit];
            if (fb_bit == 3'd0) begin
                fb_bit = 3'd7;
                if (fb_idx >= len + 1) begin
                    fb_idx    = -4;
                    msg_ready = 1'b0;
                end else begin
                    fb_idx = fb_idx + 1;
                end
            end else begin
                fb_bit = fb_bit - 3'd1;
            end
        end else begin
            // line level is held when not calibrating
            if (cfg_cal && !locked)
                line_lvl = cfg_pat[pat_phase];
            pat_phase = pat_phase - 3'd1;
        end
    endfunction

    // model one accepted input beat and queue what the block must answer
    function automatic void predict_link_step(input logic cmd, input logic rxb,
                                              input logic [7:0] hc);
        t_link_result r;
        t_rx_event    ev;
        logic [7:0]   data;
        r.committed = 1'b0;
        ev   = EV_NONE;
        data = '0;
        beats_sent++;
        if (cmd) begin
            // characters while busy are ignored
            if (!msg_ready) begin
                if (hc == CHAR_NL) begin
                    if (fill_idx != 5'd0) begin
                        msg_len     = fill_idx;
                        msg_ready   = 1'b1;
                        fill_idx    = '0;
                        r.committed = 1'b1;
                    end
                end else if (fill_idx < ABL_BUFFER_BYTES) begin
                    msg_buf[fill_idx] = hc;
                    fill_idx          = fill_idx + 5'd1;
                end
            end
        end else begin
            shift_in_rx_bit(rxb, ev, data);
            advance_tx_bit();
        end
        r.tx_level = line_lvl;
        r.rx_event = ev;
        r.rx_byte  = data;
        r.busy     = msg_ready;
        pending_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // result sink: random stalls, long hold-off on request, checks every beat
    // ------------------------------------------------------------------------
    task automatic check_result(input logic [15:0] d);
        t_link_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result beat %0d with nothing expected: %h", results_seen, d);
            return;
        end
        want = pending_results.pop_front();
        if (d[0] !== want.tx_level || d[3:1] !== want.rx_event || d[11:4] !== want.rx_byte
            || d[12] !== want.committed || d[13] !== want.busy || d[15:14] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result beat %0d: exp tx=%0b ev=%0d byte=%h commit=%0b busy=%0b",
                         results_seen, want.tx_level, want.rx_event, want.rx_byte,
                         want.committed, want.busy);
                $display("result beat %0d: got tx=%0b ev=%0d byte=%h commit=%0b busy=%0b pad=%b",
                         results_seen, d[0], d[3:1], d[11:4], d[12], d[13], d[15:14]);
            end
        end
        // tally what the run exercised
        case (want.rx_event)
            EV_CALIB:    n_calib++;
            EV_RAW:      n_raw++;
            EV_PAYLOAD:  n_payload++;
            EV_END_OK:   n_end_ok++;
            EV_END_MISS: n_end_miss++;
            default: ;
        endcase
        if (want.committed)
            n_commit++;
    endtask

    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
                stall = sink_gaps_on ? $urandom_range(0, 13) : 0;
            end
            // hold-off wins over the per-beat stall
            if (hold_off > 0) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one input beat; valid stays up between back-to-back beats
    task automatic send_beat(input logic cmd, input logic rxb, input logic [7:0] hc);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'b0, hc, rxb};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_link_step(cmd, rxb, hc);
    endtask

    // unused field of each beat carries random bits
    task automatic send_bit(input logic b);
        send_beat(1'b0, b, 8'($urandom));
    endtask

    task automatic send_char(input logic [7:0] c);
        send_beat(1'b1, 1'($urandom), c);
    endtask

    // a byte on the receive line, msb first
    task automatic feed_rx_byte(input logic [7:0] b);
        for (int i = 7; i >= 0; i--)
            send_bit(b[i]);
    endtask

    // receive what the block itself transmits, with a rare flipped bit
    task automatic loopback_tick();
        send_bit(line_lvl ^ ($urandom_range(0, 63) == 0));
    endtask

    // pad the receive line up to the next byte boundary
    task automatic rx_align();
        int fill;
        fill = (cfg_cal && !locked) || rx_left == 3'd7 ? 0 : int'(rx_left) + 1;
        repeat (fill)
            send_bit(1'b0);
    endtask

    // start, two length chars, payload, end byte; cut short after keep_bytes
    task automatic feed_frame(input logic [7:0] len_hi, input logic [7:0] len_lo,
                              input int n_bytes, input logic [7:0] end_byte,
                              input int keep_bytes);
        logic [7:0] frame_bytes[$];
        frame_bytes.push_back(SYM_START);
        frame_bytes.push_back(len_hi);
        frame_bytes.push_back(len_lo);
        for (int i = 0; i < n_bytes; i++)
            frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(end_byte);
        foreach (frame_bytes[i])
            if (i < keep_bytes)
                feed_rx_byte(frame_bytes[i]);
    endtask

    // sender pauses until every expected beat is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write; only called while the block is idle
    task automatic write_reg(input t_cfg_index idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_CAL_ENABLE: cfg_cal     = val[0];
            CFG_SYNC_PAT:   cfg_pat     = val;
            default:        cfg_promisc = val[0];
        endcase
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // lock on the reset pattern, then raw bytes through the filter
    task automatic test_calibration_and_raw();
        feed_rx_byte(PATTERN_RST);
        feed_rx_byte(8'h5A);
        feed_rx_byte(IDLE_LOW);
        feed_rx_byte(IDLE_HIGH);
        feed_rx_byte(PATTERN_RST);
    endtask

    // empty newline, store overflow, commit, characters while busy
    task automatic test_host_buffer();
        logic [7:0] c;
        send_char(CHAR_NL);
        send_char(IDLE_LOW);
        send_char(IDLE_HIGH);
        send_char(8'h55);
        send_char(8'hAA);
        // fill past the end of the store; the last two are dropped
        repeat (14) begin
            c = 8'($urandom);
            send_char(c == CHAR_NL ? 8'h0B : c);
        end
        send_char(CHAR_NL);
        send_char(8'h78);
        send_char(CHAR_NL);
    endtask

    // deframer with calibration off: good, bad-end, odd length chars
    task automatic test_deframer();
        drain_results();
        write_reg(CFG_CAL_ENABLE, {7'($urandom), 1'b0});
        write_reg(CFG_PROMISC, {7'($urandom), 1'b0});
        rx_align();
        // junk while waiting for start is dropped
        feed_rx_byte(8'h3C);
        feed_frame(nibble_to_ascii(4'd0), nibble_to_ascii(4'd2), 2, SYM_END, 64);
        feed_frame(nibble_to_ascii(4'd0), nibble_to_ascii(4'd0), 0, 8'h42, 64);
        // lower-case letter as length, taken modulo 16
        feed_frame(nibble_to_ascii(4'd0), 8'h7A, 3, SYM_END, 64);
    endtask

    // sink holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        src_gaps_on = 1'b0;
        hold_off    = 80;
        repeat (40)
            loopback_tick();
        drain_results();
        src_gaps_on = 1'b1;
    endtask

    // random episodes: settings, host messages on loopback, frames, noise
    task automatic test_random_traffic();
        int         episode;
        int         cfg_round;
        int         pick;
        int         n;
        logic       cal_v;
        logic       prom_v;
        logic [7:0] pat_v;
        logic [7:0] hi;
        logic [7:0] lo;
        episode   = 0;
        cfg_round = 0;
        while (beats_sent < TARGET_BEATS) begin
            if (episode % 4 == 0) begin
                // extremes first, then random settings
                case (cfg_round)
                    0:       begin cal_v = 1'b1; pat_v = IDLE_HIGH; prom_v = 1'b1; end
                    1:       begin cal_v = 1'b0; pat_v = IDLE_LOW;  prom_v = 1'b0; end
                    2:       begin cal_v = 1'b1; pat_v = IDLE_LOW;  prom_v = 1'b0; end
                    default: begin
                        cal_v  = 1'($urandom);
                        pat_v  = 8'($urandom);
                        prom_v = ($urandom_range(0, 2) == 0);
                    end
                endcase
                cfg_round++;
                drain_results();
                write_reg(CFG_SYNC_PAT, pat_v);
                write_reg(CFG_CAL_ENABLE, {7'($urandom), cal_v});
                write_reg(CFG_PROMISC, {7'($urandom), prom_v});
            end
            src_gaps_on  = ($urandom_range(0, 3) != 0);
            sink_gaps_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                // host message, then let the frame go out and come back
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 18)
                                                : $urandom_range(0, 5);
                if (msg_ready)
                    send_char(8'($urandom));
                while (msg_ready)
                    loopback_tick();
                repeat (n)
                    send_char(8'($urandom));
                send_char(CHAR_NL);
                while (msg_ready)
                    loopback_tick();
                repeat ($urandom_range(0, 16))
                    loopback_tick();
            end else if (pick < 8) begin
                // mostly well-formed frames, some broken or cut short
                rx_align();
                if ($urandom_range(0, 2) == 0)
                    feed_rx_byte(8'($urandom));
                n  = $urandom_range(0, 5);
                hi = ($urandom_range(0, 5) == 0) ? 8'h10 : nibble_to_ascii(4'd0);
                lo = ($urandom_range(0, 3) == 0) ? {4'h6, 4'(n + 7)}
                                                 : nibble_to_ascii(4'(n));
                feed_frame(hi, lo, n + ($urandom_range(0, 5) == 0),
                           ($urandom_range(0, 6) == 0) ? 8'($urandom) : SYM_END,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 64);
            end else begin
                // line noise
                repeat ($urandom_range(4, 20))
                    send_bit(1'($urandom));
            end
            episode++;
        end
    endtask

    initial begin : test_sequence
        for (int i = 0; i < ABL_BUFFER_BYTES; i++)
            msg_buf[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_calibration_and_raw();
        test_host_buffer();
        test_deframer();
        test_backpressure();
        test_random_traffic();

        // settle, then a short tail for anything stray
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("coverage: %0d input beats, %0d result beats, %0d messages committed",
                 beats_sent, results_seen, n_commit);
        $display("receive side: %0d lock, %0d raw, %0d payload, %0d ends ok, %0d ends missing",
                 n_calib, n_raw, n_payload, n_end_ok, n_end_miss);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ask_bit_link_framer_unit_tb: done, clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("ask_bit_link_framer_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
